@@ rtl/core/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, off while reset is held
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// property checked on the rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

@@ rtl/core/ftpcp_pkg.sv @@
// types, codes and verb table for the ftp command line parser
// no dependencies; used by ftpcp_classify and ftp_command_line_parser
`default_nettype none

package ftpcp_pkg;

    typedef enum logic [1:0] {
        PH_VERB   = 2'd0,
        PH_SKIP   = 2'd1,
        PH_COPY   = 2'd2,
        PH_IGNORE = 2'd3
    } phase_t;

    typedef enum logic [4:0] {
        CMD_ERROR   = 5'd0,
        CMD_UNKNOWN = 5'd1,
        CMD_PWD     = 5'd2,
        CMD_CWD     = 5'd3,
        CMD_USER    = 5'd4,
        CMD_PASS    = 5'd5,
        CMD_CDUP    = 5'd6,
        CMD_QUIT    = 5'd7,
        CMD_PORT    = 5'd8,
        CMD_PASV    = 5'd9,
        CMD_TYPE    = 5'd10,
        CMD_MODE    = 5'd11,
        CMD_STRU    = 5'd12,
        CMD_RETR    = 5'd13,
        CMD_STOR    = 5'd14,
        CMD_SYST    = 5'd15,
        CMD_NOOP    = 5'd16,
        CMD_SIZE    = 5'd17,
        CMD_LIST    = 5'd18,
        CMD_NLST    = 5'd19,
        CMD_HELP    = 5'd20
    } cmd_t;

    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;

    localparam logic [2:0] VERB_LEN_MAX  = 3'd7;
    localparam logic [1:0] LINE_LEN_MAX  = 2'd3;
    localparam int         NUM_VERBS3    = 2;
    localparam int         NUM_VERBS4    = 17;

    localparam logic [23:0] VERBS3 [NUM_VERBS3] = '{"PWD", "CWD"};
    localparam cmd_t        CODES3 [NUM_VERBS3] = '{CMD_PWD, CMD_CWD};

    localparam logic [31:0] VERBS4 [NUM_VERBS4] = '{
        "USER", "PASS", "CDUP", "QUIT", "PORT", "PASV", "TYPE", "MODE", "STRU",
        "RETR", "STOR", "SYST", "NOOP", "SIZE", "LIST", "NLST", "HELP"
    };
    localparam cmd_t CODES4 [NUM_VERBS4] = '{
        CMD_USER, CMD_PASS, CMD_CDUP, CMD_QUIT, CMD_PORT, CMD_PASV, CMD_TYPE,
        CMD_MODE, CMD_STRU, CMD_RETR, CMD_STOR, CMD_SYST, CMD_NOOP, CMD_SIZE,
        CMD_LIST, CMD_NLST, CMD_HELP
    };

    typedef struct packed {
        logic [31:0] verb_chars;
        logic [2:0]  verb_length;
        logic [1:0]  line_length;
    } verb_state_t;

endpackage

`default_nettype wire

@@ rtl/core/ftp_command_line_parser.sv @@
// ftp control line parser top level: line state, argument copy, result register
// depends on ftpcp_pkg, ftpcp_classify and assert_macros.svh
//
//   channel  dir  data                          sideband
//   s_       in   s_tdata[7:0] data_byte        -
//   m_       out  m_tdata[7:0] arg_byte,        m_tuser[0] kind
//                 m_tdata[12:8] command
//
// one byte accepted per cycle while s_tready is high; a result shows on m_ in the cycle after its byte
// line state and the result register sit on either side of one level of logic
// s_tready is high while the result register is empty or being drained
// reset (aresetn low, synchronous) clears line state and the result valid
// a zero byte emits the command word and returns the line state to reset
`default_nettype none

module ftp_command_line_parser (
    input  var logic        aclk,
    input  var logic        aresetn,
    input  var logic        s_tvalid,
    output var logic        s_tready,
    input  var logic [7:0]  s_tdata,   // [7:0] data_byte
    output var logic        m_tvalid,
    input  var logic        m_tready,
    output var logic [15:0] m_tdata,   // [7:0] arg_byte, [12:8] command
    output var logic [0:0]  m_tuser    // [0] kind
);

    `include "assert_macros.svh"

    ftpcp_pkg::phase_t      phase_reg, phase_next;
    ftpcp_pkg::verb_state_t vstate_reg, vstate_next;
    ftpcp_pkg::cmd_t        command;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;

    logic       s_accept;
    logic       emit;
    logic       is_space;
    logic       is_eol;
    logic [7:0] folded;

    ftpcp_classify u_classify (
        .vstate  (vstate_reg),
        .command (command)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign is_space = (s_tdata == ftpcp_pkg::BYTE_SPACE);
    assign is_eol   = (s_tdata == ftpcp_pkg::BYTE_CR) || (s_tdata == ftpcp_pkg::BYTE_LF);
    assign folded   = (s_tdata >= 8'h61 && s_tdata <= 8'h7A) ? (s_tdata - 8'h20) : s_tdata;

    always_comb begin
        phase_next    = phase_reg;
        vstate_next   = vstate_reg;
        emit          = 1'b0;
        m_tuser_next  = 1'b0;
        m_tdata_next  = {3'b000, ftpcp_pkg::CMD_ERROR, s_tdata};
        if (s_tdata == ftpcp_pkg::BYTE_NUL) begin
            emit         = 1'b1;
            m_tuser_next = 1'b1;
            m_tdata_next = {3'b000, command, 8'h00};
            phase_next   = ftpcp_pkg::PH_VERB;
            vstate_next  = '0;
        end else begin
            if (vstate_reg.line_length < ftpcp_pkg::LINE_LEN_MAX) begin
                vstate_next.line_length = vstate_reg.line_length + 2'd1;
            end
            unique case (phase_reg)
                ftpcp_pkg::PH_VERB: begin
                    if (is_space || is_eol) begin
                        if (is_space && (vstate_reg.verb_length == 3'd3 ||
                                         vstate_reg.verb_length == 3'd4)) begin
                            phase_next = ftpcp_pkg::PH_SKIP;
                        end else begin
                            phase_next = ftpcp_pkg::PH_IGNORE;
                        end
                    end else begin
                        if (vstate_reg.verb_length < 3'd4) begin
                            vstate_next.verb_chars = {vstate_reg.verb_chars[23:0], folded};
                        end
                        if (vstate_reg.verb_length < ftpcp_pkg::VERB_LEN_MAX) begin
                            vstate_next.verb_length = vstate_reg.verb_length + 3'd1;
                        end
                    end
                end
                ftpcp_pkg::PH_SKIP: begin
                    if (is_eol) begin
                        phase_next = ftpcp_pkg::PH_IGNORE;
                    end else if (!is_space) begin
                        phase_next = ftpcp_pkg::PH_COPY;
                        emit       = 1'b1;
                    end
                end
                ftpcp_pkg::PH_COPY: begin
                    if (is_eol) begin
                        phase_next = ftpcp_pkg::PH_IGNORE;
                    end else begin
                        emit = 1'b1;
                    end
                end
                ftpcp_pkg::PH_IGNORE: begin
                    phase_next = ftpcp_pkg::PH_IGNORE;
                end
                default: begin
                    phase_next = ftpcp_pkg::PH_VERB;
                end
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s_tready) begin
            m_tvalid_next = s_accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= ftpcp_pkg::PH_VERB;
            vstate_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                phase_reg  <= phase_next;
                vstate_reg <= vstate_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    `ASSERT_CLK(a_term_gives_result, aclk, aresetn,
        s_accept && s_tdata == ftpcp_pkg::BYTE_NUL |=> m_tvalid && m_tuser[0])
    `ASSERT_CLK(a_term_clears_line, aclk, aresetn,
        s_accept && s_tdata == ftpcp_pkg::BYTE_NUL |=>
        phase_reg == ftpcp_pkg::PH_VERB && vstate_reg == '0)
    `ASSERT_CLK(a_silent_phases, aclk, aresetn,
        s_accept && s_tdata != ftpcp_pkg::BYTE_NUL &&
        (phase_reg == ftpcp_pkg::PH_VERB || phase_reg == ftpcp_pkg::PH_IGNORE) |=> !m_tvalid)
    `ASSERT_CLK(a_arg_needs_verb, aclk, aresetn,
        phase_reg == ftpcp_pkg::PH_SKIP || phase_reg == ftpcp_pkg::PH_COPY |->
        vstate_reg.verb_length == 3'd3 || vstate_reg.verb_length == 3'd4)

endmodule

`default_nettype wire

@@ rtl/core/ftpcp_classify.sv @@
// verb matcher: maps the collected verb and lengths to a command code
// depends on ftpcp_pkg
`default_nettype none

module ftpcp_classify (
    input  var ftpcp_pkg::verb_state_t vstate,
    output var ftpcp_pkg::cmd_t        command
);

    always_comb begin
        command = ftpcp_pkg::CMD_UNKNOWN;
        if (vstate.line_length < ftpcp_pkg::LINE_LEN_MAX) begin
            command = ftpcp_pkg::CMD_ERROR;
        end else if (vstate.verb_length == 3'd3) begin
            for (int i = 0; i < ftpcp_pkg::NUM_VERBS3; i++) begin
                if (vstate.verb_chars[23:0] == ftpcp_pkg::VERBS3[i]) begin
                    command = ftpcp_pkg::CODES3[i];
                end
            end
        end else if (vstate.verb_length == 3'd4) begin
            for (int i = 0; i < ftpcp_pkg::NUM_VERBS4; i++) begin
                if (vstate.verb_chars == ftpcp_pkg::VERBS4[i]) begin
                    command = ftpcp_pkg::CODES4[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ test/ftp_command_line_parser_checker.sv @@
// stream monitor and line parser predictor for ftp_command_line_parser
// depends on ftpcp_pkg; instantiated beside the dut by tb_ftp_command_line_parser
// compares every m_ word with the oldest predicted word, counts failures

module ftpcp_checker (
    input  var logic        aclk,
    input  var logic        aresetn,
    input  var logic        s_tvalid,
    input  var logic        s_tready,
    input  var logic [7:0]  s_tdata,
    input  var logic        m_tvalid,
    input  var logic        m_tready,
    input  var logic [15:0] m_tdata,
    input  var logic [0:0]  m_tuser,
    output int              fail_count,
    output int              pending,
    output int              words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              kind;
        logic [7:0]        arg_byte;
        ftpcp_pkg::cmd_t   command;
    } line_word_t;

    ftpcp_pkg::phase_t ph;
    logic [31:0] verb_acc;
    logic [2:0]  verb_len;
    logic [1:0]  line_len;

    line_word_t  word_q [$];
    int          mism = 0;
    int          words_seen = 0;

    function automatic logic [7:0] upcase(input logic [7:0] b);
        if (b >= 8'h61 && b <= 8'h7A) begin
            return b - 8'h20;
        end
        return b;
    endfunction

    function automatic ftpcp_pkg::cmd_t decode_verb();
        if (line_len < 2'd3) begin
            return ftpcp_pkg::CMD_ERROR;
        end
        if (verb_len == 3'd3) begin
            case (verb_acc[23:0])
                "PWD": return ftpcp_pkg::CMD_PWD;
                "CWD": return ftpcp_pkg::CMD_CWD;
                default: return ftpcp_pkg::CMD_UNKNOWN;
            endcase
        end
        if (verb_len == 3'd4) begin
            case (verb_acc)
                "USER": return ftpcp_pkg::CMD_USER;
                "PASS": return ftpcp_pkg::CMD_PASS;
                "CDUP": return ftpcp_pkg::CMD_CDUP;
                "QUIT": return ftpcp_pkg::CMD_QUIT;
                "PORT": return ftpcp_pkg::CMD_PORT;
                "PASV": return ftpcp_pkg::CMD_PASV;
                "TYPE": return ftpcp_pkg::CMD_TYPE;
                "MODE": return ftpcp_pkg::CMD_MODE;
                "STRU": return ftpcp_pkg::CMD_STRU;
                "RETR": return ftpcp_pkg::CMD_RETR;
                "STOR": return ftpcp_pkg::CMD_STOR;
                "SYST": return ftpcp_pkg::CMD_SYST;
                "NOOP": return ftpcp_pkg::CMD_NOOP;
                "SIZE": return ftpcp_pkg::CMD_SIZE;
                "LIST": return ftpcp_pkg::CMD_LIST;
                "NLST": return ftpcp_pkg::CMD_NLST;
                "HELP": return ftpcp_pkg::CMD_HELP;
                default: return ftpcp_pkg::CMD_UNKNOWN;
            endcase
        end
        return ftpcp_pkg::CMD_UNKNOWN;
    endfunction

    task automatic clear_line();
        ph       = ftpcp_pkg::PH_VERB;
        verb_acc = '0;
        verb_len = '0;
        line_len = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, output bit emits, output line_word_t w);
        bit eol;
        emits      = 1'b0;
        w.kind     = 1'b0;
        w.arg_byte = b;
        w.command  = ftpcp_pkg::CMD_ERROR;
        if (b == ftpcp_pkg::BYTE_NUL) begin
            emits      = 1'b1;
            w.kind     = 1'b1;
            w.arg_byte = 8'h00;
            w.command  = decode_verb();
            clear_line();
        end else begin
            if (line_len != ftpcp_pkg::LINE_LEN_MAX) begin
                line_len = line_len + 2'd1;
            end
            eol = (b == ftpcp_pkg::BYTE_CR) || (b == ftpcp_pkg::BYTE_LF);
            case (ph)
                ftpcp_pkg::PH_VERB: begin
                    if (b == ftpcp_pkg::BYTE_SPACE || eol) begin
                        ph = ((verb_len == 3'd3 || verb_len == 3'd4) &&
                              b == ftpcp_pkg::BYTE_SPACE)
                            ? ftpcp_pkg::PH_SKIP : ftpcp_pkg::PH_IGNORE;
                    end else begin
                        if (verb_len < 3'd4) begin
                            verb_acc = {verb_acc[23:0], upcase(b)};
                        end
                        if (verb_len != ftpcp_pkg::VERB_LEN_MAX) begin
                            verb_len = verb_len + 3'd1;
                        end
                    end
                end
                ftpcp_pkg::PH_SKIP: begin
                    if (eol) begin
                        ph = ftpcp_pkg::PH_IGNORE;
                    end else if (b != ftpcp_pkg::BYTE_SPACE) begin
                        ph    = ftpcp_pkg::PH_COPY;
                        emits = 1'b1;
                    end
                end
                ftpcp_pkg::PH_COPY: begin
                    if (eol) begin
                        ph = ftpcp_pkg::PH_IGNORE;
                    end else begin
                        emits = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mism++;
        if (mism <= 40) begin
            $display("mismatch at word %0d, %s: got 0x%0h, expected 0x%0h",
                     words_seen, what, got, want);
        end
    endtask

    always @(posedge aclk) begin
        line_word_t want;
        line_word_t next_w;
        bit         emits;
        if (!aresetn) begin
            clear_line();
            word_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (word_q.size() == 0) begin
                    report_mismatch("word with none expected", int'(m_tdata), 0);
                end else begin
                    want = word_q.pop_front();
                    if (m_tuser[0] !== want.kind) begin
                        report_mismatch("kind", int'(m_tuser[0]), int'(want.kind));
                    end
                    if (m_tdata[7:0] !== want.arg_byte) begin
                        report_mismatch("arg_byte", int'(m_tdata[7:0]), int'(want.arg_byte));
                    end
                    if (m_tdata[12:8] !== want.command) begin
                        report_mismatch("command", int'(m_tdata[12:8]), int'(want.command));
                    end
                    if (m_tdata[15:13] !== 3'b000) begin
                        report_mismatch("tdata pad bits", int'(m_tdata[15:13]), 0);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, emits, next_w);
                if (emits) begin
                    word_q.push_back(next_w);
                end
            end
        end
        pending       <= word_q.size();
        fail_count    <= mism;
        words_checked <= words_seen;
    end

endmodule

@@ test/tb_ftp_command_line_parser.sv @@
// top level bench for ftp_command_line_parser: clock, reset, line stimulus, verdict
// depends on ftpcp_pkg, the dut and ftpcp_checker (which predicts and compares)
// sender idles in bursts, receiver stalls on rotating patterns

module tb_ftp_command_line_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_LIMIT = 3000;
    localparam int BYTE_TARGET = 1680;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_BEAT,
        RX_HOLD
    } rx_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    int          fail_count;
    int          pending;
    int          words_checked;

    logic [7:0]  line_buf [$];
    int          burst_left = 0;
    bit          quiet_tx   = 1'b0;
    int          bytes_sent = 0;
    int          lines_sent = 0;
    int          idle_cycles = 0;
    logic [31:0] rx_cycle = '0;
    rx_mode_t    rx_mode  = RX_OPEN;

    string verb_names [19] = '{
        "PWD", "CWD", "USER", "PASS", "CDUP", "QUIT", "PORT", "PASV", "TYPE", "MODE",
        "STRU", "RETR", "STOR", "SYST", "NOOP", "SIZE", "LIST", "NLST", "HELP"
    };

    ftp_command_line_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ftpcp_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle[7:0] == 8'd0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= ($urandom_range(0, 9) < 6);
            RX_BEAT: m_tready <= ((rx_cycle % 5) < 3);
            default: m_tready <= ((rx_cycle % 40) < 28);
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            if (quiet_tx || $urandom_range(0, 3) == 0) begin
                gap = 0;
            end else if ($urandom_range(0, 7) == 0) begin
                gap = $urandom_range(8, 20);
            end else begin
                gap = $urandom_range(1, 4);
            end
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_buf[i]) begin
            send_byte(line_buf[i]);
        end
        lines_sent++;
    endtask

    task automatic push_text(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) begin
                c = c | 8'h20;
            end
            line_buf.push_back(c);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic make_random_line();
        int    pick;
        int    n;
        int    pos;
        string v;
        line_buf.delete();
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            // noise: any nonzero bytes
            n = $urandom_range(0, 12);
            repeat (n) line_buf.push_back(8'($urandom_range(1, 255)));
        end else begin
            if (pick < 22) begin
                n = $urandom_range(0, 8);
                repeat (n) line_buf.push_back(8'($urandom_range(8'h21, 8'hFF)));
            end else if (pick < 30) begin
                // near miss on a real verb
                v = verb_names[$urandom_range(0, 18)];
                pos = $urandom_range(0, v.len() - 1);
                v[pos] = 8'($urandom_range(8'h21, 8'hFF));
                push_text(v, 1'b1);
            end else begin
                push_text(verb_names[$urandom_range(0, 18)], 1'b1);
            end
            case ($urandom_range(0, 9))
                0: line_buf.push_back(ftpcp_pkg::BYTE_CR);
                1: line_buf.push_back(ftpcp_pkg::BYTE_LF);
                default: repeat ($urandom_range(1, 3)) line_buf.push_back(ftpcp_pkg::BYTE_SPACE);
            endcase
            n = $urandom_range(0, 8);
            repeat (n) begin
                if ($urandom_range(0, 7) == 0) begin
                    line_buf.push_back(8'($urandom_range(1, 255)));
                end else begin
                    line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
                end
            end
            if ($urandom_range(0, 3) != 0) begin
                line_buf.push_back(ftpcp_pkg::BYTE_CR);
                line_buf.push_back(ftpcp_pkg::BYTE_LF);
            end
            repeat ($urandom_range(0, 2)) line_buf.push_back(8'($urandom_range(1, 255)));
        end
        line_buf.push_back(ftpcp_pkg::BYTE_NUL);
    endtask

    initial begin
        bit paused_mid;
        int waited;
        paused_mid = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty line
        line_buf.delete();
        line_buf.push_back(ftpcp_pkg::BYTE_NUL);
        send_line();
        // too short
        line_buf.delete();
        push_text("x", 1'b0);
        line_buf.push_back(ftpcp_pkg::BYTE_LF);
        line_buf.push_back(ftpcp_pkg::BYTE_NUL);
        send_line();
        // mixed case three letter verb
        line_buf.delete();
        push_text("pWd", 1'b0);
        line_buf.push_back(ftpcp_pkg::BYTE_NUL);
        send_line();
        // verb ended by cr, no argument
        line_buf.delete();
        push_text("cwd", 1'b0);
        line_buf.push_back(ftpcp_pkg::BYTE_CR);
        line_buf.push_back(ftpcp_pkg::BYTE_NUL);
        send_line();
        // extreme argument bytes, junk after lf
        line_buf.delete();
        push_text("HeLp ", 1'b0);
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h01);
        line_buf.push_back(ftpcp_pkg::BYTE_LF);
        line_buf.push_back(8'h7F);
        line_buf.push_back(ftpcp_pkg::BYTE_NUL);
        send_line();
        // bad verb length
        line_buf.delete();
        push_text("LS d", 1'b0);
        line_buf.push_back(ftpcp_pkg::BYTE_NUL);
        send_line();
        wait_drained();

        while (bytes_sent < BYTE_TARGET) begin
            quiet_tx = ($urandom_range(0, 4) == 0);
            make_random_line();
            send_line();
            if (!paused_mid && bytes_sent >= BYTE_TARGET / 2) begin
                wait_drained();
                paused_mid = 1'b1;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);

        $display("sent %0d bytes in %0d lines, %0d result words checked",
                 bytes_sent, lines_sent, words_checked);
        $display("covered short, empty, unknown and all verb lines under bursty flow control");
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            if (pending != 0) begin
                $display("%0d expected words never arrived", pending);
            end
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
